### rtl/wrv_pkg.sv
// ----------------------------------------------------------------------------
// wrv_pkg: shared definitions for the running variance block
// Field widths, limits, step counts, sequencer states and the operand and
// result bundles of the shared compare-subtract unit.
// ----------------------------------------------------------------------------
package wrv_pkg;

    // Fixed field widths of the streaming payloads
    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 24;
    localparam int MEAN_W   = 32;
    localparam int VAR_W    = 39;
    localparam int SD_W     = 24;

    // Significant input bits and width of the sample counter
    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_BITS  = 24;

    // Internal widths
    localparam int SUM_W  = 62;
    localparam int STEP_W = 27;
    localparam int REM_W  = 25;
    localparam int WORK_W = 48;
    localparam int ITER_W = 6;

    // Number of iterations of each serial operation
    localparam int DIV1_STEPS = 32;
    localparam int DIV2_STEPS = 39;
    localparam int SQRT_STEPS = 24;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [SUM_W-1:0]      SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [VAR_W-1:0]      VAR_MAX   = {VAR_W{1'b1}};

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DELTA,
        ST_DIV1,
        ST_MEAN,
        ST_DELTA2,
        ST_MUL,
        ST_ACC,
        ST_VSET,
        ST_VCHK,
        ST_DIV2,
        ST_SQLOAD,
        ST_SQRT,
        ST_OUT
    } wrv_state_t;

    // Operands of the compare-subtract unit
    typedef struct packed {
        logic [STEP_W-1:0] minuend;
        logic [STEP_W-1:0] subtrahend;
    } wrv_step_in_t;

    // Result of the compare-subtract unit
    typedef struct packed {
        logic              ge;
        logic [STEP_W-1:0] diff;
    } wrv_step_out_t;

endpackage

### rtl/wrv_sample_if.sv
// ----------------------------------------------------------------------------
// wrv_sample_if: sample stream channel
// Valid/ready channel that carries one signed sample per transfer.
// ----------------------------------------------------------------------------
interface wrv_sample_if;

    logic                                valid;
    logic                                ready;
    logic signed [wrv_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);

endinterface

### rtl/wrv_result_if.sv
// ----------------------------------------------------------------------------
// wrv_result_if: statistics result channel
// Valid/ready channel that carries count, mean, variance, standard deviation
// and the saturation flag in one transfer.
// ----------------------------------------------------------------------------
interface wrv_result_if;

    logic                              valid;
    logic                              ready;
    logic [wrv_pkg::COUNT_W-1:0]       sample_count;
    logic signed [wrv_pkg::MEAN_W-1:0] running_mean;
    logic [wrv_pkg::VAR_W-1:0]         sample_variance;
    logic [wrv_pkg::SD_W-1:0]          std_deviation;
    logic                              saturated;

    modport source (
        output valid, output sample_count, output running_mean,
        output sample_variance, output std_deviation, output saturated,
        input ready
    );
    modport sink (
        input valid, input sample_count, input running_mean,
        input sample_variance, input std_deviation, input saturated,
        output ready
    );

endinterface

### rtl/welford_running_variance.sv
// ----------------------------------------------------------------------------
// welford_running_variance: Welford online mean and variance
// A small sequencer drives one shared compare-subtract unit through the mean
// division, the variance division and the square root of each sample.
// ----------------------------------------------------------------------------
// Work per sample: 32 divide steps for the mean, 39 for the variance and 24
//   root steps, plus control states (the variance division is skipped while
//   the count is below two or the variance clamps; at the count limit the
//   mean division is skipped as well).
// Samples are accepted only in the idle state; the unit is shared by all.
// Reset clears count, mean, sum of squares, saturation flag and sequencer.
// ----------------------------------------------------------------------------
module welford_running_variance (
    input  logic                 clk,
    input  logic                 rst_n,
    wrv_sample_if.sink           sample_ch,
    wrv_result_if.source         result_ch
);
    import wrv_pkg::*;

    // Sequencer and statistics state
    wrv_state_t              state_reg, state_next;
    logic [ITER_W-1:0]       iter_reg, iter_next;
    logic [COUNT_BITS-1:0]   count_reg, count_next;
    logic [MEAN_W-1:0]       mean_reg, mean_next;
    logic [SUM_W-1:0]        square_sum_reg, square_sum_next;
    logic                    saturated_reg, saturated_next;

    // Working registers
    logic [MEAN_W-1:0]       x_reg, x_next;
    logic [MEAN_W-1:0]       dmag_reg, dmag_next;
    logic                    dneg_reg, dneg_next;
    logic [MEAN_W-1:0]       d2mag_reg, d2mag_next;
    logic                    d2neg_reg, d2neg_next;
    logic                    opp_reg, opp_next;
    logic [2*MEAN_W-1:0]     prod_reg, prod_next;
    logic [COUNT_BITS-1:0]   div_reg, div_next;
    logic [REM_W-1:0]        rem_reg, rem_next;
    logic [WORK_W-1:0]       work_reg, work_next;
    logic [SD_W-1:0]         root_reg, root_next;
    logic [VAR_W-1:0]        var_reg, var_next;

    // Output register
    logic                    out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0]      out_count_reg, out_count_next;
    logic [MEAN_W-1:0]       out_mean_reg, out_mean_next;
    logic [VAR_W-1:0]        out_var_reg, out_var_next;
    logic [SD_W-1:0]         out_sd_reg, out_sd_next;
    logic                    out_sat_reg, out_sat_next;

    // Combinational helpers
    wrv_step_in_t                step_in;
    wrv_step_out_t               step_out;
    logic signed [SAMPLE_BITS-1:0] sample_trunc;
    logic [SAMPLE_W-1:0]         sample_ext;
    logic [MEAN_W:0]             delta_wide;
    logic [MEAN_W:0]             delta_abs;
    logic [MEAN_W:0]             quot_wide;
    logic [MEAN_W:0]             quot_signed;
    logic [SUM_W:0]              sum_wide;
    logic [WORK_W-1:0]           work_div;
    logic                        sample_xfer;

    wrv_step_unit u_step (
        .step_in  (step_in),
        .step_out (step_out)
    );

    // Handshake and result port
    assign sample_xfer               = sample_ch.valid && sample_ch.ready;
    assign sample_ch.ready           = (state_reg == ST_IDLE);
    assign result_ch.valid           = out_valid_reg;
    assign result_ch.sample_count    = out_count_reg;
    assign result_ch.running_mean    = out_mean_reg;
    assign result_ch.sample_variance = out_var_reg;
    assign result_ch.std_deviation   = out_sd_reg;
    assign result_ch.saturated       = out_sat_reg;

    // Only the significant sample bits count; they are sign extended.
    assign sample_trunc = sample_ch.sample[SAMPLE_BITS-1:0];
    assign sample_ext   = SAMPLE_W'(sample_trunc);

    // Operand selection for the shared unit
    always_comb
    begin
        step_in = '0;
        if (state_reg == ST_SQRT)
        begin
            step_in.minuend    = {rem_reg, work_reg[WORK_W-1 -: 2]};
            step_in.subtrahend = {1'b0, root_reg, 2'b01};
        end
        else
        begin
            step_in.minuend    = {1'b0, rem_reg, work_reg[WORK_W-1]};
            step_in.subtrahend = STEP_W'(div_reg);
        end
    end

    // Datapath helpers shared by several states
    assign work_div    = {work_reg[WORK_W-2:0], step_out.ge};
    assign quot_wide   = {1'b0, work_reg[MEAN_W-1:0]};
    assign quot_signed = dneg_reg ? ((MEAN_W+1)'(0) - quot_wide) : quot_wide;
    assign delta_abs   = delta_wide[MEAN_W] ? ((MEAN_W+1)'(0) - delta_wide) : delta_wide;
    assign sum_wide    = {1'b0, square_sum_reg} +
                         (SUM_W+1)'(opp_reg ? 40'd0 : prod_reg[2*MEAN_W-1:24]);

    // Delta against the current mean; used before and after the mean update.
    assign delta_wide = {x_reg[MEAN_W-1], x_reg} - {mean_reg[MEAN_W-1], mean_reg};

    // Sequencer: next state and datapath updates
    always_comb
    begin
        state_next      = state_reg;
        iter_next       = iter_reg;
        count_next      = count_reg;
        mean_next       = mean_reg;
        square_sum_next = square_sum_reg;
        saturated_next  = saturated_reg;
        x_next          = x_reg;
        dmag_next       = dmag_reg;
        dneg_next       = dneg_reg;
        d2mag_next      = d2mag_reg;
        d2neg_next      = d2neg_reg;
        opp_next        = opp_reg;
        prod_next       = prod_reg;
        div_next        = div_reg;
        rem_next        = rem_reg;
        work_next       = work_reg;
        root_next       = root_reg;
        var_next        = var_reg;
        out_valid_next  = out_valid_reg && !result_ch.ready;
        out_count_next  = out_count_reg;
        out_mean_next   = out_mean_reg;
        out_var_next    = out_var_reg;
        out_sd_next     = out_sd_reg;
        out_sat_next    = out_sat_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_xfer)
                begin
                    if (count_reg == COUNT_MAX)
                    begin
                        // Count limit: the sample is dropped, statistics stay.
                        saturated_next = 1'b1;
                        state_next     = ST_VSET;
                    end
                    else
                    begin
                        count_next = count_reg + COUNT_BITS'(1);
                        x_next     = {sample_ext, 16'd0};
                        state_next = ST_DELTA;
                    end
                end
            end

            ST_DELTA:
            begin
                dneg_next  = delta_wide[MEAN_W];
                dmag_next  = delta_abs[MEAN_W-1:0];
                work_next  = {delta_abs[MEAN_W-1:0], (WORK_W-MEAN_W)'(0)};
                rem_next   = '0;
                div_next   = count_reg;
                iter_next  = '0;
                state_next = ST_DIV1;
            end

            // Restoring division of |delta| by the new count
            ST_DIV1:
            begin
                rem_next  = step_out.ge ? step_out.diff[REM_W-1:0]
                                        : step_in.minuend[REM_W-1:0];
                work_next = work_div;
                iter_next = iter_reg + ITER_W'(1);
                if (iter_reg == ITER_W'(DIV1_STEPS - 1))
                begin
                    state_next = ST_MEAN;
                end
            end

            ST_MEAN:
            begin
                mean_next  = mean_reg + quot_signed[MEAN_W-1:0];
                state_next = ST_DELTA2;
            end

            ST_DELTA2:
            begin
                d2neg_next = delta_wide[MEAN_W];
                d2mag_next = delta_abs[MEAN_W-1:0];
                state_next = ST_MUL;
            end

            ST_MUL:
            begin
                prod_next  = dmag_reg * d2mag_reg;
                opp_next   = dneg_reg ^ d2neg_reg;
                state_next = ST_ACC;
            end

            // Accumulate with saturation at the top of the sum range
            ST_ACC:
            begin
                square_sum_next = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
                state_next      = ST_VSET;
            end

            ST_VSET:
            begin
                if (count_reg < COUNT_BITS'(2))
                begin
                    var_next   = '0;
                    state_next = ST_SQLOAD;
                end
                else
                begin
                    div_next   = count_reg - COUNT_BITS'(1);
                    state_next = ST_VCHK;
                end
            end

            // A quotient that would not fit the variance width clamps at once.
            ST_VCHK:
            begin
                if ({1'b0, square_sum_reg} >= {div_reg, (SUM_W+1-COUNT_BITS)'(0)})
                begin
                    var_next   = VAR_MAX;
                    state_next = ST_SQLOAD;
                end
                else
                begin
                    rem_next   = REM_W'(square_sum_reg[SUM_W-1:VAR_W]);
                    work_next  = {square_sum_reg[VAR_W-1:0], (WORK_W-VAR_W)'(0)};
                    iter_next  = '0;
                    state_next = ST_DIV2;
                end
            end

            // Restoring division of the sum by count minus one
            ST_DIV2:
            begin
                rem_next  = step_out.ge ? step_out.diff[REM_W-1:0]
                                        : step_in.minuend[REM_W-1:0];
                work_next = work_div;
                iter_next = iter_reg + ITER_W'(1);
                if (iter_reg == ITER_W'(DIV2_STEPS - 1))
                begin
                    var_next   = work_div[VAR_W-1:0];
                    state_next = ST_SQLOAD;
                end
            end

            ST_SQLOAD:
            begin
                work_next  = {1'b0, var_reg, 8'd0};
                rem_next   = '0;
                root_next  = '0;
                iter_next  = '0;
                state_next = ST_SQRT;
            end

            // Digit-by-digit square root, two radicand bits per step
            ST_SQRT:
            begin
                if (step_out.ge)
                begin
                    rem_next  = step_out.diff[REM_W-1:0];
                    root_next = {root_reg[SD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = step_in.minuend[REM_W-1:0];
                    root_next = {root_reg[SD_W-2:0], 1'b0};
                end
                work_next = {work_reg[WORK_W-3:0], 2'b00};
                iter_next = iter_reg + ITER_W'(1);
                if (iter_reg == ITER_W'(SQRT_STEPS - 1))
                begin
                    state_next = ST_OUT;
                end
            end

            // Load the output register once the previous result is taken
            ST_OUT:
            begin
                if (!out_valid_reg || result_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = COUNT_W'(count_reg);
                    out_mean_next  = mean_reg;
                    out_var_next   = var_reg;
                    out_sd_next    = root_reg;
                    out_sat_next   = saturated_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and statistics registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            iter_reg       <= '0;
            count_reg      <= '0;
            mean_reg       <= '0;
            square_sum_reg <= '0;
            saturated_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            iter_reg       <= iter_next;
            count_reg      <= count_next;
            mean_reg       <= mean_next;
            square_sum_reg <= square_sum_next;
            saturated_reg  <= saturated_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Working and output payload registers
    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        dmag_reg      <= dmag_next;
        dneg_reg      <= dneg_next;
        d2mag_reg     <= d2mag_next;
        d2neg_reg     <= d2neg_next;
        opp_reg       <= opp_next;
        prod_reg      <= prod_next;
        div_reg       <= div_next;
        rem_reg       <= rem_next;
        work_reg      <= work_next;
        root_reg      <= root_next;
        var_reg       <= var_next;
        out_count_reg <= out_count_next;
        out_mean_reg  <= out_mean_next;
        out_var_reg   <= out_var_next;
        out_sd_reg    <= out_sd_next;
        out_sat_reg   <= out_sat_next;
    end

    // A sample transfer starts a computation, so the next cycle is busy.
    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        sample_xfer |=> !sample_ch.ready)
        else $error("sequencer accepted a sample while busy");

    // The saturation flag only clears at reset.
    a_sat_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        saturated_reg |=> saturated_reg)
        else $error("saturation flag cleared");

    // The count only ever moves up by one.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> (count_reg == $past(count_reg) + COUNT_BITS'(1)))
        else $error("sample count changed by other than one");

    // A new result appears only when the sequencer finishes.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_OUT))
        else $error("result became valid outside the output state");

endmodule

### rtl/wrv_step_unit.sv
// ----------------------------------------------------------------------------
// wrv_step_unit: shared compare-subtract unit
// One trial subtraction per cycle; serves both restoring divisions and the
// digit-by-digit square root.
// ----------------------------------------------------------------------------
module wrv_step_unit (
    input  wrv_pkg::wrv_step_in_t  step_in,
    output wrv_pkg::wrv_step_out_t step_out
);
    import wrv_pkg::*;

    logic [STEP_W:0] wide_diff;

    // Subtract with borrow; no borrow means the minuend is not the smaller one.
    assign wide_diff     = {1'b0, step_in.minuend} - {1'b0, step_in.subtrahend};
    assign step_out.ge   = ~wide_diff[STEP_W];
    assign step_out.diff = wide_diff[STEP_W-1:0];

endmodule
